>>> rtl/tlshello_pkg.sv
package tlshello_pkg;

  // Default width of the payload byte position counter.
  localparam int POSITION_BITS_DEF = 16;

  // Number of leading payload bytes kept for the header checks.
  localparam int HDR_KEEP = 12;

  // Position of the TLS session id length byte in a client hello.
  localparam int SESSION_AT = 43;

  // Width of the tracked TLS field position (at most 44 + 255 + 2).
  localparam int FT_W = 9;

  // Width of an end offset: cipher offset plus a 16-bit length plus one.
  localparam int END_W = 17;

  // Byte values used by the header checks.
  localparam logic [7:0] BYTE_HANDSHAKE = 8'h16;
  localparam logic [7:0] BYTE_MAJOR_V3  = 8'h03;
  localparam logic [7:0] BYTE_V2_LONG   = 8'h80;
  localparam logic [7:0] MASK_LEN_TWO   = 8'h7F;
  localparam logic [7:0] MASK_LEN_THREE = 8'h3F;
  localparam logic [7:0] HS_CLIENT_BYTE = 8'h01;
  localparam logic [7:0] HS_SERVER_BYTE = 8'h02;

  // Accepted protocol versions.
  localparam logic [15:0] VER_TLS10 = 16'h0301;
  localparam logic [15:0] VER_SSL2  = 16'h0002;
  localparam logic [15:0] VER_SSL3  = 16'h0003;

  // Application label reported for a recognized hello.
  localparam logic [8:0] LABEL_TLS = 9'd443;

  // Result variant codes.
  localparam logic [1:0] VAR_NONE      = 2'd0;
  localparam logic [1:0] VAR_V2_TWO    = 2'd1;
  localparam logic [1:0] VAR_V2_THREE  = 2'd2;
  localparam logic [1:0] VAR_TLS       = 2'd3;

  // Handshake type codes.
  localparam logic [1:0] HS_NONE   = 2'd0;
  localparam logic [1:0] HS_CLIENT = 2'd1;
  localparam logic [1:0] HS_SERVER = 2'd2;

  // Progress through the TLS client hello toward the cipher list length.
  typedef enum logic [3:0] {
    PH_HDR    = 4'b0001,
    PH_LEN_HI = 4'b0010,
    PH_LEN_LO = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef logic [7:0] hdr_t [HDR_KEEP];

  function automatic logic version_ok(input logic [15:0] v);
    return (v == VER_TLS10) || (v == VER_SSL2) || (v == VER_SSL3);
  endfunction

endpackage

>>> rtl/tls_sslv2_hello_classifier.sv
// Channel | Direction | Handshake           | Payload
// in_     | input     | in_valid / in_stall  | in_data_byte, in_last_byte
// out_    | output    | out_valid / out_stall| app_label, recognized, variant,
//         |           |                      | handshake_type, versions, cipher list
//
// One payload byte is taken per cycle while in_stall is low; the verdict for a payload appears in the
// output register on the cycle after its last byte is accepted.
// The per-byte parse and the final judgement sit between the state registers
// and the output register, so the sustained rate is one byte per cycle while in_stall stays low.
// rst_n is synchronous and active low; it clears the parse state and the output valid.
// in_stall rises only while a finished result waits in the output register and
// out_stall is high.
module tls_sslv2_hello_classifier #(
  parameter int POSITION_BITS = tlshello_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [8:0]  out_app_label,
  output logic        out_recognized,
  output logic [1:0]  out_variant,
  output logic [1:0]  out_handshake_type,
  output logic [15:0] out_record_version,
  output logic [15:0] out_hello_version,
  output logic [15:0] out_cipher_list_offset,
  output logic [15:0] out_cipher_list_length
);

  localparam int CMP_W = (POSITION_BITS > tlshello_pkg::END_W) ?
                         POSITION_BITS : tlshello_pkg::END_W;
  localparam logic [POSITION_BITS-1:0] MAX_POS = '1;
  localparam int FT_W = tlshello_pkg::FT_W;

  // Parse state.
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  tlshello_pkg::hdr_t       hdr_r, hdr_nxt;
  tlshello_pkg::phase_t     phase_r, phase_nxt;
  logic [FT_W-1:0]          ft_r, ft_nxt;
  logic [7:0]               acc_r, acc_nxt;
  logic [15:0]              clen_r, clen_nxt;
  logic [FT_W-1:0]          coff_r, coff_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  logic [8:0]  label_r;
  logic        recog_r;
  logic [1:0]  variant_r;
  logic [1:0]  hs_r;
  logic [15:0] rver_r;
  logic [15:0] hver_r;
  logic [15:0] coff_out_r;
  logic [15:0] clen_out_r;

  logic in_acc;
  logic pos_live;

  assign in_stall = out_valid_r & out_stall;
  assign in_acc   = in_valid & ~in_stall;
  assign pos_live = (pos_r != MAX_POS);

  // Per-byte update: header capture and the walk to the cipher list length.
  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    phase_nxt = phase_r;
    ft_nxt    = ft_r;
    acc_nxt   = acc_r;
    clen_nxt  = clen_r;
    coff_nxt  = coff_r;
    if (pos_live) begin
      for (int i = 0; i < tlshello_pkg::HDR_KEEP; i++) begin
        if (CMP_W'(pos_r) == CMP_W'(i)) begin
          hdr_nxt[i] = in_data_byte;
        end
      end
      case (phase_r)
        tlshello_pkg::PH_HDR: begin
          if (CMP_W'(pos_r) == CMP_W'(tlshello_pkg::SESSION_AT)) begin
            ft_nxt    = FT_W'(tlshello_pkg::SESSION_AT + 1) + FT_W'(in_data_byte);
            phase_nxt = tlshello_pkg::PH_LEN_HI;
          end
        end
        tlshello_pkg::PH_LEN_HI: begin
          if (CMP_W'(pos_r) == CMP_W'(ft_r)) begin
            acc_nxt   = in_data_byte;
            phase_nxt = tlshello_pkg::PH_LEN_LO;
          end
        end
        tlshello_pkg::PH_LEN_LO: begin
          if (CMP_W'(pos_r) == CMP_W'(ft_r) + CMP_W'(1)) begin
            clen_nxt  = {acc_r, in_data_byte};
            coff_nxt  = ft_r + FT_W'(2);
            phase_nxt = tlshello_pkg::PH_DONE;
          end
        end
        default: begin
        end
      endcase
      pos_nxt = pos_r + POSITION_BITS'(1);
    end
  end

  // Payload length as judged: saturates with the position counter.
  logic [CMP_W-1:0] size;
  assign size = pos_live ? CMP_W'(pos_r) + CMP_W'(1) : CMP_W'(pos_r);

  // Verdict on the payload ending with the current byte.
  logic        j_ok;
  logic [1:0]  j_variant;
  logic [1:0]  j_hs;
  logic [15:0] j_rver;
  logic [15:0] j_hver;
  logic [15:0] j_coff;
  logic [15:0] j_clen;

  always_comb begin
    logic [7:0]       h0;
    logic [7:0]       h1;
    logic [14:0]      len_two;
    logic [13:0]      len_three;
    logic             is_v3_rec;
    logic [15:0]      ver_two;
    logic [15:0]      ver_three;
    logic [15:0]      cl_two;
    logic [15:0]      cl_three;
    logic [CMP_W-1:0] end_two;
    logic [CMP_W-1:0] end_three;
    logic [CMP_W-1:0] end_client;
    logic [CMP_W-1:0] end_server;
    logic             tls_common;
    h0         = hdr_nxt[0];
    h1         = hdr_nxt[1];
    len_two    = {h0[6:0] & tlshello_pkg::MASK_LEN_TWO[6:0], h1};
    len_three  = {h0[5:0] & tlshello_pkg::MASK_LEN_THREE[5:0], h1};
    is_v3_rec  = (h0 == tlshello_pkg::BYTE_HANDSHAKE) && (h1 == tlshello_pkg::BYTE_MAJOR_V3);
    ver_two    = {hdr_nxt[3], hdr_nxt[4]};
    ver_three  = {hdr_nxt[4], hdr_nxt[5]};
    cl_two     = {hdr_nxt[5], hdr_nxt[6]};
    cl_three   = {hdr_nxt[6], hdr_nxt[7]};
    end_two    = CMP_W'(11) + CMP_W'(cl_two);
    end_three  = CMP_W'(12) + CMP_W'(cl_three);
    end_client = CMP_W'(coff_nxt) + CMP_W'(clen_nxt) + CMP_W'(1);
    end_server = CMP_W'(ft_nxt) + CMP_W'(3);

    j_ok      = 1'b0;
    j_variant = tlshello_pkg::VAR_NONE;
    j_hs      = tlshello_pkg::HS_NONE;
    j_rver    = '0;
    j_hver    = '0;
    j_coff    = '0;
    j_clen    = '0;

    tls_common = (size >= CMP_W'(45)) && is_v3_rec &&
                 ((hdr_nxt[5] == tlshello_pkg::HS_CLIENT_BYTE) ||
                  (hdr_nxt[5] == tlshello_pkg::HS_SERVER_BYTE)) &&
                 (((hdr_nxt[3] == 8'h00) && (hdr_nxt[4] < 8'd5)) || (hdr_nxt[9] == h1)) &&
                 (phase_nxt != tlshello_pkg::PH_HDR);

    if (size >= CMP_W'(5)) begin
      if ((h0 & tlshello_pkg::BYTE_V2_LONG) != 8'h00) begin
        // SSLv2 client hello with a two-byte record header.
        if ((hdr_nxt[2] == tlshello_pkg::HS_CLIENT_BYTE) && (len_two >= 15'd2) &&
            tlshello_pkg::version_ok(ver_two) && (size >= CMP_W'(11)) &&
            (end_two <= size)) begin
          j_ok      = 1'b1;
          j_variant = tlshello_pkg::VAR_V2_TWO;
          j_hs      = tlshello_pkg::HS_CLIENT;
          j_rver    = ver_two;
          j_coff    = 16'd11;
          j_clen    = cl_two;
        end
      end else if (!h0[6] && (hdr_nxt[3] == tlshello_pkg::HS_CLIENT_BYTE) && !is_v3_rec) begin
        // SSLv2 client hello with a three-byte record header.
        if ((len_three >= 14'd3) && tlshello_pkg::version_ok(ver_three) &&
            (size >= CMP_W'(12)) && (end_three <= size)) begin
          j_ok      = 1'b1;
          j_variant = tlshello_pkg::VAR_V2_THREE;
          j_hs      = tlshello_pkg::HS_CLIENT;
          j_rver    = ver_three;
          j_coff    = 16'd12;
          j_clen    = cl_three;
        end
      end else if (tls_common) begin
        // SSLv3/TLS client or server hello.
        if (hdr_nxt[5] == tlshello_pkg::HS_CLIENT_BYTE) begin
          if ((phase_nxt == tlshello_pkg::PH_DONE) && (end_client <= size)) begin
            j_ok   = 1'b1;
            j_hs   = tlshello_pkg::HS_CLIENT;
            j_coff = 16'(coff_nxt);
            j_clen = clen_nxt;
          end
        end else if (end_server <= size) begin
          j_ok = 1'b1;
          j_hs = tlshello_pkg::HS_SERVER;
        end
        if (j_ok) begin
          j_variant = tlshello_pkg::VAR_TLS;
          j_rver    = {hdr_nxt[1], hdr_nxt[2]};
          j_hver    = {hdr_nxt[9], hdr_nxt[10]};
        end
      end
    end
  end

  // Parse state registers; cleared after each payload's last byte.
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_last_byte)) begin
      pos_r   <= '0;
      phase_r <= tlshello_pkg::PH_HDR;
      ft_r    <= '0;
      acc_r   <= '0;
      clen_r  <= '0;
      coff_r  <= '0;
      for (int i = 0; i < tlshello_pkg::HDR_KEEP; i++) begin
        hdr_r[i] <= '0;
      end
    end else if (in_acc) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      ft_r    <= ft_nxt;
      acc_r   <= acc_nxt;
      clen_r  <= clen_nxt;
      coff_r  <= coff_nxt;
      hdr_r   <= hdr_nxt;
    end
  end

  // Output valid: set by a last byte, cleared when the result is taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc && in_last_byte) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (in_acc && in_last_byte) begin
      label_r    <= j_ok ? tlshello_pkg::LABEL_TLS : 9'd0;
      recog_r    <= j_ok;
      variant_r  <= j_variant;
      hs_r       <= j_hs;
      rver_r     <= j_rver;
      hver_r     <= j_hver;
      coff_out_r <= j_coff;
      clen_out_r <= j_clen;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_app_label          = label_r;
  assign out_recognized         = recog_r;
  assign out_variant            = variant_r;
  assign out_handshake_type     = hs_r;
  assign out_record_version     = rver_r;
  assign out_hello_version      = hver_r;
  assign out_cipher_list_offset = coff_out_r;
  assign out_cipher_list_length = clen_out_r;

`ifndef SYNTHESIS
  // A byte that is not the last never produces a transaction on the output.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_last_byte && !out_stall) |=> !out_valid)
    else $error("result appeared without a last byte");

  // The parse state is back at its start after every payload.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_last_byte) |=> (pos_r == '0) && (phase_r == tlshello_pkg::PH_HDR))
    else $error("parse state not cleared after last byte");

  // An unrecognized payload reports zero in its label, variant, handshake type, record version and cipher list length.
  a_unrecognized_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_recognized) |->
      (out_app_label == 9'd0) && (out_variant == tlshello_pkg::VAR_NONE) &&
      (out_handshake_type == tlshello_pkg::HS_NONE) && (out_record_version == 16'd0) &&
      (out_cipher_list_length == 16'd0))
    else $error("unrecognized result carries nonzero fields");

  // A recognized payload carries the label, a variant and a handshake type.
  a_recognized_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_recognized) |->
      (out_app_label == tlshello_pkg::LABEL_TLS) &&
      (out_variant != tlshello_pkg::VAR_NONE) &&
      (out_handshake_type != tlshello_pkg::HS_NONE))
    else $error("recognized result is inconsistent");
`endif

endmodule

>>> dv/tls_hello_checker.sv
// Watches both channels of the hello classifier, predicts a verdict for each
// payload and compares every output transaction with the oldest prediction.
module tls_hello_checker
  import tlshello_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [8:0]  out_app_label,
  input  logic        out_recognized,
  input  logic [1:0]  out_variant,
  input  logic [1:0]  out_handshake_type,
  input  logic [15:0] out_record_version,
  input  logic [15:0] out_hello_version,
  input  logic [15:0] out_cipher_list_offset,
  input  logic [15:0] out_cipher_list_length,
  output int          errors,
  output int          pending,
  output int          verdicts_seen,
  output int          hellos_seen
);

  localparam int unsigned MAX_POS = (1 << POSITION_BITS_DEF) - 1;
  localparam int unsigned V2_TWO_BODY = 11;
  localparam int unsigned V2_THREE_BODY = 12;
  localparam int unsigned V2_THREE_MIN = 7;
  localparam int unsigned TLS_HDR_MIN = 10;
  localparam int unsigned TLS_BODY_MIN = 45;

  typedef struct packed {
    logic [8:0]  label;
    logic        recog;
    logic [1:0]  variant;
    logic [1:0]  hs;
    logic [15:0] rver;
    logic [15:0] hver;
    logic [15:0] coff;
    logic [15:0] clen;
  } verdict_t;

  // Parse state of the payload currently arriving.
  int unsigned pos_cnt;
  hdr_t        hdr;
  phase_t      phase;
  int unsigned sess_target;
  logic [7:0]  len_hi;
  logic [15:0] cipher_len;
  int unsigned cipher_off;

  verdict_t verdict_q[$];
  verdict_t want;

  function automatic logic [15:0] be16(input int unsigned at);
    return {hdr[at], hdr[at+1]};
  endfunction

  function automatic logic accepted_version(input logic [15:0] v);
    return v == VER_TLS10 || v == VER_SSL2 || v == VER_SSL3;
  endfunction

  // Classify the payload from the captured header and the TLS field walk.
  function automatic verdict_t judge_hello(input int unsigned n);
    verdict_t v;
    logic [15:0] ver;
    logic [15:0] clen;
    v = '0;
    if (n < 5) return v;
    if (hdr[0][7]) begin
      // SSLv2 with a two-byte record header.
      if (hdr[2] != HS_CLIENT_BYTE || {hdr[0][6:0], hdr[1]} < 2) return v;
      ver = be16(3);
      if (!accepted_version(ver) || n < V2_TWO_BODY) return v;
      clen = be16(5);
      if (V2_TWO_BODY + clen > n) return v;
      v.variant = VAR_V2_TWO;
      v.hs = HS_CLIENT;
      v.rver = ver;
      v.coff = 16'(V2_TWO_BODY);
      v.clen = clen;
    end else if (!hdr[0][6] && hdr[3] == HS_CLIENT_BYTE &&
                 !(hdr[0] == BYTE_HANDSHAKE && hdr[1] == BYTE_MAJOR_V3)) begin
      // SSLv2 with a three-byte record header.
      if ({hdr[0][5:0], hdr[1]} < 3 || n < V2_THREE_MIN) return v;
      ver = be16(4);
      if (!accepted_version(ver) || n < V2_THREE_BODY) return v;
      clen = be16(6);
      if (V2_THREE_BODY + clen > n) return v;
      v.variant = VAR_V2_THREE;
      v.hs = HS_CLIENT;
      v.rver = ver;
      v.coff = 16'(V2_THREE_BODY);
      v.clen = clen;
    end else begin
      // SSLv3 or TLS handshake record.
      if (n < TLS_HDR_MIN || hdr[0] != BYTE_HANDSHAKE || hdr[1] != BYTE_MAJOR_V3) return v;
      if (hdr[5] != HS_CLIENT_BYTE && hdr[5] != HS_SERVER_BYTE) return v;
      if (!((hdr[3] == 8'h00 && hdr[4] < 5) || hdr[9] == hdr[1])) return v;
      if (n < TLS_BODY_MIN || phase == PH_HDR) return v;
      if (hdr[5] == HS_CLIENT_BYTE) begin
        if (phase != PH_DONE) return v;
        if (cipher_off + cipher_len + 1 > n) return v;
        v.hs = HS_CLIENT;
        v.coff = cipher_off[15:0];
        v.clen = cipher_len;
      end else begin
        if (sess_target + 3 > n) return v;
        v.hs = HS_SERVER;
      end
      v.variant = VAR_TLS;
      v.rver = be16(1);
      v.hver = be16(9);
    end
    v.label = LABEL_TLS;
    v.recog = 1'b1;
    return v;
  endfunction

  task automatic clear_parse();
    pos_cnt = 0;
    foreach (hdr[i]) hdr[i] = 8'h00;
    phase = PH_HDR;
    sess_target = 0;
    len_hi = 8'h00;
    cipher_len = 16'h0000;
    cipher_off = 0;
  endtask

  // Advance the parse by one payload byte; the last byte yields a verdict.
  task automatic take_byte(input logic [7:0] b, input logic fin);
    int unsigned at;
    int unsigned seen;
    at = pos_cnt;
    if (at < MAX_POS) begin
      if (at < HDR_KEEP) hdr[at] = b;
      if (phase == PH_HDR && at == SESSION_AT) begin
        sess_target = SESSION_AT + 1 + b;
        phase = PH_LEN_HI;
      end else if (phase == PH_LEN_HI && at == sess_target) begin
        len_hi = b;
        phase = PH_LEN_LO;
      end else if (phase == PH_LEN_LO && at == sess_target + 1) begin
        cipher_len = {len_hi, b};
        cipher_off = sess_target + 2;
        phase = PH_DONE;
      end
      pos_cnt = at + 1;
    end
    if (fin) begin
      seen = (at < MAX_POS) ? at + 1 : MAX_POS;
      verdict_q.push_back(judge_hello(seen));
      clear_parse();
    end
  endtask

  task automatic check_field(input string name, input int unsigned exp_val,
                             input int unsigned got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endtask

  // Output transactions are checked before the input of the same edge is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      verdict_q.delete();
      errors = 0;
      verdicts_seen = 0;
      hellos_seen = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected verdict: expected none, got label %0d variant %0d",
                   $time, out_app_label, out_variant);
        end else begin
          want = verdict_q.pop_front();
          check_field("app_label", want.label, out_app_label);
          check_field("recognized", want.recog, out_recognized);
          check_field("variant", want.variant, out_variant);
          check_field("handshake_type", want.hs, out_handshake_type);
          check_field("record_version", want.rver, out_record_version);
          check_field("hello_version", want.hver, out_hello_version);
          check_field("cipher_list_offset", want.coff, out_cipher_list_offset);
          check_field("cipher_list_length", want.clen, out_cipher_list_length);
          verdicts_seen++;
          if (want.recog) hellos_seen++;
        end
      end
      if (in_valid && !in_stall) take_byte(in_data_byte, in_last_byte);
    end
    pending = verdict_q.size();
  end

endmodule

>>> dv/tls_sslv2_hello_classifier_test.sv
// Drives payloads into the hello classifier under changing stall patterns.
module tls_sslv2_hello_classifier_test;
  import tlshello_pkg::*;

  localparam int CYCLE_LIMIT = 100000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_stall;
  logic [8:0]  out_app_label;
  logic        out_recognized;
  logic [1:0]  out_variant;
  logic [1:0]  out_handshake_type;
  logic [15:0] out_record_version;
  logic [15:0] out_hello_version;
  logic [15:0] out_cipher_list_offset;
  logic [15:0] out_cipher_list_length;

  int errors;
  int pending;
  int verdicts_seen;
  int hellos_seen;

  int cycle_cnt = 0;
  int bytes_sent = 0;
  int pkts_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // Payload being assembled for the next send.
  logic [7:0] pkt[$];

  tls_sslv2_hello_classifier u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_app_label(out_app_label),
    .out_recognized(out_recognized),
    .out_variant(out_variant),
    .out_handshake_type(out_handshake_type),
    .out_record_version(out_record_version),
    .out_hello_version(out_hello_version),
    .out_cipher_list_offset(out_cipher_list_offset),
    .out_cipher_list_length(out_cipher_list_length)
  );

  tls_hello_checker u_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_app_label(out_app_label),
    .out_recognized(out_recognized),
    .out_variant(out_variant),
    .out_handshake_type(out_handshake_type),
    .out_record_version(out_record_version),
    .out_hello_version(out_hello_version),
    .out_cipher_list_offset(out_cipher_list_offset),
    .out_cipher_list_length(out_cipher_list_length),
    .errors(errors),
    .pending(pending),
    .verdicts_seen(verdicts_seen),
    .hellos_seen(hellos_seen)
  );

  always #4 clk = ~clk;

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d verdicts outstanding", $time, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver back-pressure at the current rate.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  function automatic bit sender_idles();
    return $urandom_range(99) < send_idle_pct;
  endfunction

  function automatic logic [15:0] pick_version();
    int r;
    r = $urandom_range(9);
    if (r <= 2) return VER_TLS10;
    if (r <= 5) return VER_SSL2;
    if (r <= 7) return VER_SSL3;
    return 16'($urandom);
  endfunction

  // One byte transaction; the sender may idle first, never while stalled.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while (sender_idles()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= fin;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_pkt();
    foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
    bytes_sent += pkt.size();
    pkts_sent++;
  endtask

  task automatic push16(input logic [15:0] w);
    pkt.push_back(w[15:8]);
    pkt.push_back(w[7:0]);
  endtask

  // Pad with random bytes or cut the payload to the given length.
  task automatic fit(input int total);
    int n;
    n = (total < 1) ? 1 : total;
    while (pkt.size() < n) pkt.push_back(rnd_byte());
    while (pkt.size() > n) void'(pkt.pop_back());
  endtask

  task automatic build_v2_two(input logic [15:0] ver, input int clen, input int extra);
    int total;
    logic [14:0] rec;
    total = 11 + clen + extra;
    rec = 15'(total - 2);
    pkt.delete();
    pkt.push_back(BYTE_V2_LONG | {1'b0, rec[14:8]});
    pkt.push_back(rec[7:0]);
    pkt.push_back(HS_CLIENT_BYTE);
    push16(ver);
    push16(16'(clen));
    push16(16'd0);
    push16(16'd16);
    fit(total);
  endtask

  task automatic build_v2_three(input logic [15:0] ver, input int clen, input int extra);
    int total;
    logic [13:0] rec;
    total = 12 + clen + extra;
    rec = 14'(total - 3);
    pkt.delete();
    pkt.push_back({2'b00, rec[13:8]});
    pkt.push_back(rec[7:0]);
    pkt.push_back(rnd_byte());
    pkt.push_back(HS_CLIENT_BYTE);
    push16(ver);
    push16(16'(clen));
    push16(16'd0);
    push16(16'd16);
    fit(total);
  endtask

  // TLS client or server hello with session id and, for a client, cipher list.
  task automatic build_tls(input logic [7:0] hs_byte, input logic [7:0] rec_minor,
                           input logic [7:0] hello_minor, input int sess,
                           input int clen, input int extra);
    int total;
    total = (hs_byte == HS_CLIENT_BYTE) ? 47 + sess + clen + extra : 47 + sess + extra;
    pkt.delete();
    pkt.push_back(BYTE_HANDSHAKE);
    pkt.push_back(BYTE_MAJOR_V3);
    pkt.push_back(rec_minor);
    push16(16'(total - 5));
    pkt.push_back(hs_byte);
    pkt.push_back(8'h00);
    push16(16'(total - 9));
    pkt.push_back(BYTE_MAJOR_V3);
    pkt.push_back(hello_minor);
    repeat (32) pkt.push_back(rnd_byte());
    pkt.push_back(8'(sess));
    repeat (sess) pkt.push_back(rnd_byte());
    if (hs_byte == HS_CLIENT_BYTE) begin
      push16(16'(clen));
      repeat (clen) pkt.push_back(rnd_byte());
      pkt.push_back(8'h01);
      pkt.push_back(8'h00);
    end else begin
      push16({rnd_byte(), rnd_byte()});
      pkt.push_back(8'h00);
    end
    fit(total);
  endtask

  // Hand-picked payloads: field extremes, every hello form and reject paths.
  task automatic run_directed();
    pkt = {8'h00};
    send_pkt();
    pkt = {8'hFF, 8'hFF, 8'hFF, 8'hFF};
    send_pkt();
    build_v2_two(VER_SSL2, 3, 0);
    send_pkt();
    build_v2_two(VER_SSL3, 3, 0);
    send_pkt();
    build_v2_two(VER_TLS10, 3, 0);
    send_pkt();
    // Unknown version.
    build_v2_two(16'h0200, 3, 0);
    send_pkt();
    // Record length below the minimum.
    build_v2_two(VER_SSL2, 0, 0);
    pkt[0] = BYTE_V2_LONG;
    pkt[1] = 8'h01;
    send_pkt();
    // Cipher list runs past the end of the payload.
    build_v2_two(VER_SSL3, 20, -1);
    send_pkt();
    build_v2_two(VER_TLS10, 0, 5);
    pkt[5] = 8'hFF;
    pkt[6] = 8'hFF;
    send_pkt();
    build_v2_three(VER_TLS10, 6, 2);
    send_pkt();
    build_v2_three(VER_SSL2, 0, 0);
    pkt[0] = 8'h00;
    pkt[1] = 8'h02;
    send_pkt();
    // A three-byte header that looks like a TLS record goes the TLS way.
    build_v2_three(VER_SSL3, 4, 0);
    pkt[0] = BYTE_HANDSHAKE;
    pkt[1] = BYTE_MAJOR_V3;
    send_pkt();
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 0, 2, 0);
    send_pkt();
    build_tls(HS_CLIENT_BYTE, 8'h03, 8'h03, 32, 10, 1);
    send_pkt();
    build_tls(HS_CLIENT_BYTE, 8'h00, 8'h00, 255, 0, 0);
    send_pkt();
    // Payload ends just before the cipher list length.
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 8, 4, -7);
    send_pkt();
    // Too short for a TLS hello body.
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 0, 0, -3);
    send_pkt();
    build_tls(HS_SERVER_BYTE, 8'h01, 8'h01, 16, 0, 0);
    send_pkt();
    build_tls(HS_SERVER_BYTE, 8'h02, 8'h02, 0, 0, -1);
    send_pkt();
    // Handshake type that is neither client nor server.
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 0, 2, 0);
    pkt[5] = 8'h04;
    send_pkt();
    // Long record with a foreign hello version byte.
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 0, 2, 0);
    pkt[3] = 8'h01;
    pkt[9] = 8'h02;
    send_pkt();
    // Short record length lets a foreign hello version byte pass.
    build_tls(HS_CLIENT_BYTE, 8'h01, 8'h01, 0, 2, 0);
    pkt[3] = 8'h00;
    pkt[4] = 8'h02;
    pkt[9] = 8'h02;
    send_pkt();
  endtask

  // Mostly well-formed hellos with random content; some noise and damage.
  task automatic random_payload();
    int pick;
    int r;
    int extra;
    int sess;
    int clen;
    logic [15:0] ver;
    pick = $urandom_range(99);
    r = $urandom_range(99);
    extra = (r < 70) ? $urandom_range(3) :
            (r < 85) ? -int'($urandom_range(3, 1)) : $urandom_range(20);
    ver = pick_version();
    clen = ($urandom_range(99) < 90) ? $urandom_range(24) : $urandom_range(300);
    sess = ($urandom_range(99) < 90) ? $urandom_range(32) : 255;
    if (pick < 15) begin
      pkt.delete();
      fit($urandom_range(60, 1));
    end else if (pick < 35) begin
      build_v2_two(ver, clen, extra);
    end else if (pick < 55) begin
      build_v2_three(ver, clen, extra);
    end else if (pick < 85) begin
      build_tls(HS_CLIENT_BYTE, 8'($urandom_range(3)), 8'($urandom_range(3)),
                sess, clen % 64, extra);
    end else begin
      build_tls(HS_SERVER_BYTE, 8'($urandom_range(3)), 8'($urandom_range(3)),
                sess, 0, extra);
    end
    if (pick >= 15 && $urandom_range(99) < 15)
      pkt[$urandom_range((pkt.size() < 12 ? pkt.size() : 12) - 1)] = rnd_byte();
  endtask

  task automatic random_phase();
    int b0;
    int p0;
    b0 = bytes_sent;
    p0 = pkts_sent;
    while (bytes_sent - b0 < 80 || pkts_sent - p0 < 3) begin
      random_payload();
      send_pkt();
    end
  endtask

  // Reset, then directed payloads and three random traffic phases, then drain and report.
  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = 8'h00;
    in_last_byte = 1'b0;
    out_stall = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 22;
    stall_pct = 78;
    run_directed();
    random_phase();
    send_idle_pct = 78;
    stall_pct = 22;
    random_phase();
    send_idle_pct = 0;
    stall_pct = 0;
    random_phase();
    in_valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    $display("Sent %0d payloads (%0d bytes) under three back-pressure patterns.",
             pkts_sent, bytes_sent);
    $display("Checked %0d verdicts, %0d of them recognized hellos.",
             verdicts_seen, hellos_seen);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
